// ----- design/ccc_pkg.sv -----
// ccc_pkg: shared types for the circle contact pipeline
// used by ccc_sqrt, ccc_div and circle_circle_contact
package ccc_pkg;

  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 16;

  typedef struct packed {
    logic               hit;
    logic               zero;
    logic signed [25:0] dx;
    logic signed [25:0] dy;
    logic        [23:0] rs;
    logic signed [25:0] csx;
    logic signed [25:0] csy;
    logic signed [23:0] rdiff;
    logic        [23:0] depth;
  } ctx_t;

  typedef struct packed {
    logic               hit;
    logic        [23:0] depth;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [23:0] contact_x;
    logic signed [23:0] contact_y;
  } res_t;

endpackage

// ----- design/ccc_pair_if.sv -----
// ccc_pair_if: valid/ready channel carrying one circle pair item
// no dependencies
interface ccc_pair_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] pos_a_x;
  logic signed [23:0] pos_a_y;
  logic signed [23:0] off_a_x;
  logic signed [23:0] off_a_y;
  logic        [22:0] radius_a;
  logic signed [23:0] pos_b_x;
  logic signed [23:0] pos_b_y;
  logic signed [23:0] off_b_x;
  logic signed [23:0] off_b_y;
  logic        [22:0] radius_b;

  modport source (output valid, pos_a_x, pos_a_y, off_a_x, off_a_y, radius_a,
                  pos_b_x, pos_b_y, off_b_x, off_b_y, radius_b, input ready);
  modport sink (input valid, pos_a_x, pos_a_y, off_a_x, off_a_y, radius_a,
                pos_b_x, pos_b_y, off_b_x, off_b_y, radius_b, output ready);
endinterface

// ----- design/ccc_res_if.sv -----
// ccc_res_if: valid/ready channel carrying one contact result item
// no dependencies
interface ccc_res_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic        [23:0] depth;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [23:0] contact_x;
  logic signed [23:0] contact_y;

  modport source (output valid, hit, depth, norm_x, norm_y, contact_x, contact_y,
                  input ready);
  modport sink (input valid, hit, depth, norm_x, norm_y, contact_x, contact_y,
                output ready);
endinterface

// ----- design/ccc_sqrt.sv -----
// ccc_sqrt: pipelined integer square root, one result bit per stage
// depends on ccc_pkg for the context carried alongside
module ccc_sqrt (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_v,
  input  logic [63:0]         in_x,
  input  ccc_pkg::ctx_t       in_ctx,
  output logic                out_v,
  output logic [31:0]         out_root,
  output ccc_pkg::ctx_t       out_ctx
);

  logic                v    [0:ccc_pkg::SqrtSteps];
  logic [34:0]         rem  [0:ccc_pkg::SqrtSteps];
  logic [31:0]         root [0:ccc_pkg::SqrtSteps];
  logic [63:0]         xs   [0:ccc_pkg::SqrtSteps];
  ccc_pkg::ctx_t       ctx  [0:ccc_pkg::SqrtSteps];

  assign v[0]    = in_v;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign xs[0]   = in_x;
  assign ctx[0]  = in_ctx;

  for (genvar k = 0; k < ccc_pkg::SqrtSteps; k++) begin : g_step
    logic [34:0] r4;
    logic [34:0] trial;
    logic        ge;

    assign r4    = {rem[k][32:0], xs[k][63:62]};
    assign trial = {1'b0, root[k], 2'b01};
    assign ge    = r4 >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? r4 - trial : r4;
        root[k+1] <= {root[k][30:0], ge};
        xs[k+1]   <= {xs[k][61:0], 2'b00};
        ctx[k+1]  <= ctx[k];
      end
    end
  end

  assign out_v    = v[ccc_pkg::SqrtSteps];
  assign out_root = root[ccc_pkg::SqrtSteps];
  assign out_ctx  = ctx[ccc_pkg::SqrtSteps];

endmodule

// ----- design/ccc_div.sv -----
// ccc_div: two-lane pipelined restoring divider, one quotient bit per stage
// depends on ccc_pkg; quotient assumed below 2^16, shared divisor
module ccc_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_v,
  input  logic [49:0]         in_num_x,
  input  logic [49:0]         in_num_y,
  input  logic [32:0]         in_den,
  input  ccc_pkg::ctx_t       in_ctx,
  output logic                out_v,
  output logic [15:0]         out_q_x,
  output logic [15:0]         out_q_y,
  output ccc_pkg::ctx_t       out_ctx
);

  logic                v   [0:ccc_pkg::DivSteps];
  logic [32:0]         den [0:ccc_pkg::DivSteps];
  ccc_pkg::ctx_t       ctx [0:ccc_pkg::DivSteps];
  logic [33:0]         rem [0:1][0:ccc_pkg::DivSteps];
  logic [15:0]         lo  [0:1][0:ccc_pkg::DivSteps];
  logic [15:0]         q   [0:1][0:ccc_pkg::DivSteps];

  assign v[0]      = in_v;
  assign den[0]    = in_den;
  assign ctx[0]    = in_ctx;
  assign rem[0][0] = in_num_x[49:16];
  assign lo[0][0]  = in_num_x[15:0];
  assign q[0][0]   = '0;
  assign rem[1][0] = in_num_y[49:16];
  assign lo[1][0]  = in_num_y[15:0];
  assign q[1][0]   = '0;

  for (genvar k = 0; k < ccc_pkg::DivSteps; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den[k+1] <= den[k];
        ctx[k+1] <= ctx[k];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [34:0] r2;
      logic [34:0] dd;
      logic        ge;

      assign r2 = {rem[l][k], lo[l][k][15]};
      assign dd = {2'b00, den[k]};
      assign ge = r2 >= dd;

      always_ff @(posedge clk) begin
        if (en) begin
          rem[l][k+1] <= ge ? 34'(r2 - dd) : r2[33:0];
          lo[l][k+1]  <= {lo[l][k][14:0], 1'b0};
          q[l][k+1]   <= {q[l][k][14:0], ge};
        end
      end
    end
  end

  assign out_v   = v[ccc_pkg::DivSteps];
  assign out_q_x = q[0][ccc_pkg::DivSteps];
  assign out_q_y = q[1][ccc_pkg::DivSteps];
  assign out_ctx = ctx[ccc_pkg::DivSteps];

endmodule

// ----- design/circle_circle_contact.sv -----
// circle_circle_contact: top level of the pipelined circle contact test
// depends on ccc_pkg, ccc_pair_if, ccc_res_if, ccc_sqrt and ccc_div
//
// usage:
//   pair carries one circle pair per item, res gives one result per item,
//   in the same order. both are valid/ready channels.
//   there are 58 register stages: five front stages
//   (centres, differences, squares, sum, compare), 32 square root stages,
//   one divider setup stage, 16 divider stages, three stages for normal,
//   product and rounded contact, and the output register. throughput is
//   one item per cycle while the pipeline is not frozen; the square root
//   and divider each resolve one bit per stage, so every stage takes a new
//   item each cycle that the pipeline is not frozen.
//   when res stalls, the output register holds and a one-item skid stage
//   takes the next finished result; only when the skid is full does the
//   whole pipeline freeze and pair.ready go low. nothing is dropped.
//   rst (synchronous) clears all valid bits; the pipeline comes out empty
//   and ready in the next cycle.
module circle_circle_contact (
  input  logic clk,
  input  logic rst,
  ccc_pair_if.sink  pair,
  ccc_res_if.source res
);

  logic en;

  // front stage 1: centres
  logic               f1_v;
  logic signed [24:0] f1_cax, f1_cay, f1_cbx, f1_cby;
  logic        [22:0] f1_ra, f1_rb;
  // front stage 2: differences
  logic               f2_v;
  ccc_pkg::ctx_t      f2_ctx;
  // front stage 3: squares
  logic               f3_v;
  logic        [51:0] f3_sqx, f3_sqy;
  logic        [47:0] f3_rs2;
  ccc_pkg::ctx_t      f3_ctx;
  // front stage 4: squared distance
  logic               f4_v;
  logic        [51:0] f4_dsq;
  logic        [47:0] f4_rs2;
  ccc_pkg::ctx_t      f4_ctx;
  // front stage 5: compare
  logic               f5_v;
  logic        [63:0] f5_x;
  ccc_pkg::ctx_t      f5_ctx;
  ccc_pkg::ctx_t      f5_ctx_next;

  logic               sq_v;
  logic        [31:0] sq_root;
  ccc_pkg::ctx_t      sq_ctx;

  // divider setup
  logic               p_v;
  logic        [49:0] p_num_x, p_num_y;
  logic        [32:0] p_den;
  ccc_pkg::ctx_t      p_ctx;
  ccc_pkg::ctx_t      p_ctx_next;
  logic        [25:0] mag_x, mag_y;
  logic        [32:0] dist_rnd;

  logic               dv_v;
  logic        [15:0] dv_qx, dv_qy;
  ccc_pkg::ctx_t      dv_ctx;

  // tail stages
  logic               t1_v;
  logic signed [15:0] t1_nx, t1_ny;
  ccc_pkg::ctx_t      t1_ctx;
  logic signed [15:0] nx_next, ny_next;

  logic               t2_v;
  logic signed [39:0] t2_px, t2_py;
  logic signed [15:0] t2_nx, t2_ny;
  ccc_pkg::ctx_t      t2_ctx;

  logic               t3_v;
  ccc_pkg::res_t      t3_res;
  ccc_pkg::res_t      res_next;
  logic signed [41:0] sum_x, sum_y;
  logic signed [25:0] rnd_x, rnd_y;

  // output register and skid
  logic               ov, sv;
  ccc_pkg::res_t      od, sd;
  logic               push, pop;

  assign en         = !sv;
  assign pair.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
      f3_v <= 1'b0;
      f4_v <= 1'b0;
      f5_v <= 1'b0;
      p_v  <= 1'b0;
      t1_v <= 1'b0;
      t2_v <= 1'b0;
      t3_v <= 1'b0;
    end else if (en) begin
      f1_v <= pair.valid;
      f2_v <= f1_v;
      f3_v <= f2_v;
      f4_v <= f3_v;
      f5_v <= f4_v;
      p_v  <= sq_v;
      t1_v <= dv_v;
      t2_v <= t1_v;
      t3_v <= t2_v;
    end
  end

  always_comb begin
    f5_ctx_next      = f4_ctx;
    f5_ctx_next.hit  = f4_dsq <= {4'h0, f4_rs2};
    f5_ctx_next.zero = f4_dsq == '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_cax <= 25'(pair.pos_a_x) + 25'(pair.off_a_x);
      f1_cay <= 25'(pair.pos_a_y) + 25'(pair.off_a_y);
      f1_cbx <= 25'(pair.pos_b_x) + 25'(pair.off_b_x);
      f1_cby <= 25'(pair.pos_b_y) + 25'(pair.off_b_y);
      f1_ra  <= pair.radius_a;
      f1_rb  <= pair.radius_b;

      f2_ctx.hit   <= 1'b0;
      f2_ctx.zero  <= 1'b0;
      f2_ctx.dx    <= 26'(f1_cbx) - 26'(f1_cax);
      f2_ctx.dy    <= 26'(f1_cby) - 26'(f1_cay);
      f2_ctx.rs    <= {1'b0, f1_ra} + {1'b0, f1_rb};
      f2_ctx.csx   <= 26'(f1_cax) + 26'(f1_cbx);
      f2_ctx.csy   <= 26'(f1_cay) + 26'(f1_cby);
      f2_ctx.rdiff <= $signed({1'b0, f1_ra}) - $signed({1'b0, f1_rb});
      f2_ctx.depth <= '0;

      f3_sqx <= 52'(f2_ctx.dx * f2_ctx.dx);
      f3_sqy <= 52'(f2_ctx.dy * f2_ctx.dy);
      f3_rs2 <= 48'(f2_ctx.rs * f2_ctx.rs);
      f3_ctx <= f2_ctx;

      f4_dsq <= f3_sqx + f3_sqy;
      f4_rs2 <= f3_rs2;
      f4_ctx <= f3_ctx;

      f5_x   <= {f4_dsq[47:0], 16'h0000};
      f5_ctx <= f5_ctx_next;
    end
  end

  ccc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (f5_v),
    .in_x     (f5_x),
    .in_ctx   (f5_ctx),
    .out_v    (sq_v),
    .out_root (sq_root),
    .out_ctx  (sq_ctx)
  );

  assign mag_x    = sq_ctx.dx[25] ? 26'(-sq_ctx.dx) : sq_ctx.dx;
  assign mag_y    = sq_ctx.dy[25] ? 26'(-sq_ctx.dy) : sq_ctx.dy;
  assign dist_rnd = ({1'b0, sq_root} + 33'd128) >> 8;

  always_comb begin
    p_ctx_next       = sq_ctx;
    p_ctx_next.depth = sq_ctx.zero ? sq_ctx.rs : sq_ctx.rs - dist_rnd[23:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_num_x <= {mag_x, 24'h000000} + {18'h00000, sq_root};
      p_num_y <= {mag_y, 24'h000000} + {18'h00000, sq_root};
      p_den   <= {sq_root, 1'b0};
      p_ctx   <= p_ctx_next;
    end
  end

  ccc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (p_v),
    .in_num_x (p_num_x),
    .in_num_y (p_num_y),
    .in_den   (p_den),
    .in_ctx   (p_ctx),
    .out_v    (dv_v),
    .out_q_x  (dv_qx),
    .out_q_y  (dv_qy),
    .out_ctx  (dv_ctx)
  );

  // sign and saturate the normal; coincident centres get the +x normal
  always_comb begin
    if (dv_ctx.zero) begin
      nx_next = 16'sh7fff;
      ny_next = '0;
    end else begin
      if (dv_ctx.dx[25]) begin
        nx_next = (dv_qx > 16'd32768) ? 16'sh8000 : 16'(-dv_qx);
      end else begin
        nx_next = (dv_qx > 16'd32767) ? 16'sh7fff : dv_qx;
      end
      if (dv_ctx.dy[25]) begin
        ny_next = (dv_qy > 16'd32768) ? 16'sh8000 : 16'(-dv_qy);
      end else begin
        ny_next = (dv_qy > 16'd32767) ? 16'sh7fff : dv_qy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_nx  <= nx_next;
      t1_ny  <= ny_next;
      t1_ctx <= dv_ctx;

      t2_px  <= 40'(t1_nx * t1_ctx.rdiff);
      t2_py  <= 40'(t1_ny * t1_ctx.rdiff);
      t2_nx  <= t1_nx;
      t2_ny  <= t1_ny;
      t2_ctx <= t1_ctx;

      t3_res <= res_next;
    end
  end

  // round half up and saturate the contact point
  assign sum_x = ($signed({t2_ctx.csx, 15'h0000}) + 42'(t2_px)) + 42'sd32768;
  assign sum_y = ($signed({t2_ctx.csy, 15'h0000}) + 42'(t2_py)) + 42'sd32768;
  assign rnd_x = sum_x[41:16];
  assign rnd_y = sum_y[41:16];

  always_comb begin
    res_next = '0;
    if (t2_ctx.hit) begin
      res_next.hit    = 1'b1;
      res_next.depth  = t2_ctx.depth;
      res_next.norm_x = t2_nx;
      res_next.norm_y = t2_ny;
      if (rnd_x > 26'sd8388607) begin
        res_next.contact_x = 24'sh7fffff;
      end else if (rnd_x < -26'sd8388608) begin
        res_next.contact_x = 24'sh800000;
      end else begin
        res_next.contact_x = rnd_x[23:0];
      end
      if (rnd_y > 26'sd8388607) begin
        res_next.contact_y = 24'sh7fffff;
      end else if (rnd_y < -26'sd8388608) begin
        res_next.contact_y = 24'sh800000;
      end else begin
        res_next.contact_y = rnd_y[23:0];
      end
    end
  end

  // output register with one-item skid
  assign push = en && t3_v;
  assign pop  = ov && res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (pop) begin
      if (sv) begin
        sv <= 1'b0;
      end else begin
        ov <= push;
      end
    end else if (push) begin
      if (!ov) begin
        ov <= 1'b1;
      end else begin
        sv <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (sv) begin
        od <= sd;
      end else if (push) begin
        od <= t3_res;
      end
    end else if (push) begin
      if (!ov) begin
        od <= t3_res;
      end else begin
        sd <= t3_res;
      end
    end
  end

  assign res.valid     = ov;
  assign res.hit       = od.hit;
  assign res.depth     = od.depth;
  assign res.norm_x    = od.norm_x;
  assign res.norm_y    = od.norm_y;
  assign res.contact_x = od.contact_x;
  assign res.contact_y = od.contact_y;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    sv |-> ov)
    else $error("skid holds an item while output register is empty");

  a_stall_keeps_item: assert property (@(posedge clk) disable iff (rst)
    ov && !res.ready |=> ov)
    else $error("stalled result lost");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    ov && !od.hit |-> od.depth == '0 && od.norm_x == '0 && od.norm_y == '0
      && od.contact_x == '0 && od.contact_y == '0)
    else $error("miss result carries nonzero fields");

  a_hit_has_normal: assert property (@(posedge clk) disable iff (rst)
    ov && od.hit |-> !(od.norm_x == '0 && od.norm_y == '0))
    else $error("hit without a normal");

endmodule

// ----- verif/circle_circle_contact_test.sv -----
// circle_circle_contact_test: checks the pipelined circle contact block against a
// local fixed point model of the collision test, with random stalls on both sides
// depends on ccc_pkg, ccc_pair_if, ccc_res_if and circle_circle_contact
module circle_circle_contact_test;

  typedef struct {
    logic signed [23:0] pax, pay, oax, oay;
    logic        [22:0] ra;
    logic signed [23:0] pbx, pby, obx, oby;
    logic        [22:0] rb;
  } pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors = 0;
  int   idle_cycles = 0;
  int   hold_off = 0;
  bit   done = 0;
  ccc_pkg::res_t contact_q[$];

  ccc_pair_if pair ();
  ccc_res_if  res ();

  circle_circle_contact dut (.clk(clk), .rst(rst), .pair(pair), .res(res));

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] normal_of(longint d, longint unsigned h);
    longint unsigned m, q;
    m = (d < 0) ? -d : d;
    q = ((m << 24) + h) / (h << 1);
    if (d < 0) return (q > 32768) ? -16'sd32768 : 16'(-longint'(q));
    return (q > 32767) ? 16'sd32767 : 16'(q);
  endfunction

  function automatic logic signed [23:0] contact_of(longint cs, longint n, longint rd);
    longint s, r;
    s = cs * 32768 + n * rd + 32768;
    r = s >>> 16;
    if (r > 8388607) return 24'sh7fffff;
    if (r < -8388608) return 24'sh800000;
    return 24'(r);
  endfunction

  function automatic ccc_pkg::res_t contact_of_pair(pair_t p);
    ccc_pkg::res_t o;
    longint cax, cay, cbx, cby, dx, dy, ra, rb;
    longint unsigned dsq, rs, h, dist_rnd;
    o = '0;
    cax = longint'(p.pax) + p.oax;
    cay = longint'(p.pay) + p.oay;
    cbx = longint'(p.pbx) + p.obx;
    cby = longint'(p.pby) + p.oby;
    ra = p.ra;
    rb = p.rb;
    dx = cbx - cax;
    dy = cby - cay;
    dsq = dx * dx + dy * dy;
    rs = ra + rb;
    if (dsq > rs * rs) return o;
    o.hit = 1'b1;
    if (dsq == 0) begin
      o.depth = rs;
      o.norm_x = 16'sd32767;
      o.norm_y = 0;
    end else begin
      h = isqrt(dsq << 16);
      dist_rnd = (h + 128) >> 8;
      o.depth = rs - dist_rnd;
      o.norm_x = normal_of(dx, h);
      o.norm_y = normal_of(dy, h);
    end
    o.contact_x = contact_of(cax + cbx, o.norm_x, ra - rb);
    o.contact_y = contact_of(cay + cby, o.norm_y, ra - rb);
    return o;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic send_pair(pair_t p);
    int g;
    g = gap_len();
    if (g > 0) begin
      pair.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    pair.valid <= 1'b1;
    pair.pos_a_x <= p.pax;
    pair.pos_a_y <= p.pay;
    pair.off_a_x <= p.oax;
    pair.off_a_y <= p.oay;
    pair.radius_a <= p.ra;
    pair.pos_b_x <= p.pbx;
    pair.pos_b_y <= p.pby;
    pair.off_b_x <= p.obx;
    pair.off_b_y <= p.oby;
    pair.radius_b <= p.rb;
    do @(posedge clk); while (!pair.ready);
    contact_q.push_back(contact_of_pair(p));
  endtask

  function automatic pair_t near_pair(int spread);
    pair_t p;
    p.pax = 24'($urandom);
    p.pay = 24'($urandom);
    p.oax = 24'($signed($urandom_range(0, 2 * spread)) - spread);
    p.oay = 24'($signed($urandom_range(0, 2 * spread)) - spread);
    p.pbx = p.pax + 24'($signed($urandom_range(0, 2 * spread)) - spread);
    p.pby = p.pay + 24'($signed($urandom_range(0, 2 * spread)) - spread);
    p.obx = 24'($signed($urandom_range(0, 2 * spread)) - spread);
    p.oby = 24'($signed($urandom_range(0, 2 * spread)) - spread);
    p.ra = 23'($urandom_range(0, 2 * spread));
    p.rb = 23'($urandom_range(0, 2 * spread));
    return p;
  endfunction

  function automatic pair_t any_pair();
    pair_t p;
    p.pax = 24'($urandom); p.pay = 24'($urandom);
    p.oax = 24'($urandom); p.oay = 24'($urandom);
    p.pbx = 24'($urandom); p.pby = 24'($urandom);
    p.obx = 24'($urandom); p.oby = 24'($urandom);
    p.ra = 23'($urandom); p.rb = 23'($urandom);
    return p;
  endfunction

  task automatic test_directed();
    pair_t p;
    p = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_pair(p);                                   // coincident zero radius
    p.ra = 23'd256; p.rb = 23'd512;
    send_pair(p);                                   // coincident centres
    p.pbx = 24'd768;
    send_pair(p);                                   // exactly touching
    p.pbx = 24'd769;
    send_pair(p);                                   // just missing
    p.pbx = -24'sd300; p.pby = 24'd300;
    send_pair(p);
    p = '{24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 23'h7fffff,
          24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 23'h7fffff};
    send_pair(p);                                   // contact saturates high
    p = '{24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000, 23'h7fffff,
          24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000, 23'h7fffff};
    send_pair(p);                                   // contact saturates low
    p = '{24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000, 23'h7fffff,
          24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 23'h7fffff};
    send_pair(p);                                   // far apart, miss
    p = '{0, 0, 0, 0, 23'h7fffff, 24'sh800000, 0, 0, 0, 23'h7fffff};
    send_pair(p);                                   // normal x at -1.0
    p = '{0, 0, 0, 0, 23'h7fffff, 0, 24'sh7fffff, 0, 0, 0};
    send_pair(p);                                   // normal y near +1.0
    p = '{100, 100, 0, 0, 23'd50, 100, -24'sd20, 0, 0, 23'd200};
    send_pair(p);
    p = '{0, 0, 0, 0, 23'd1000, 24'd3, 24'd4, 0, 0, 23'd0};
    send_pair(p);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1: send_pair(any_pair());
        2, 3: send_pair(near_pair(8388607 / 4));
        4, 5, 6: send_pair(near_pair(4000));
        default: send_pair(near_pair(64));
      endcase
    end
  endtask

  task automatic test_backpressure();
    hold_off = 150;
    for (int i = 0; i < 120; i++) send_pair(near_pair(500));
  endtask

  task automatic drain();
    pair.valid <= 1'b0;
    while (contact_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    ccc_pkg::res_t e;
    if (!rst && res.valid && res.ready) begin
      if (contact_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = contact_q.pop_front();
        if (res.hit !== e.hit) begin
          $error("hit: expected %0d actual %0d", e.hit, res.hit); errors++;
        end
        if (res.depth !== e.depth) begin
          $error("depth: expected %0d actual %0d", e.depth, res.depth); errors++;
        end
        if (res.norm_x !== e.norm_x) begin
          $error("norm_x: expected %0d actual %0d", e.norm_x, res.norm_x); errors++;
        end
        if (res.norm_y !== e.norm_y) begin
          $error("norm_y: expected %0d actual %0d", e.norm_y, res.norm_y); errors++;
        end
        if (res.contact_x !== e.contact_x) begin
          $error("contact_x: expected %0d actual %0d", e.contact_x, res.contact_x);
          errors++;
        end
        if (res.contact_y !== e.contact_y) begin
          $error("contact_y: expected %0d actual %0d", e.contact_y, res.contact_y);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (pair.valid && pair.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
        $display("circle_circle_contact_test: errors");
        $finish;
      end
    end
  end

  initial begin
    pair.valid = 1'b0;
    {pair.pos_a_x, pair.pos_a_y, pair.off_a_x, pair.off_a_y, pair.radius_a} = '0;
    {pair.pos_b_x, pair.pos_b_y, pair.off_b_x, pair.off_b_y, pair.radius_b} = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    drain();
    test_backpressure();
    drain();
    test_random(1100);
    drain();
    repeat (80) @(posedge clk);
    done = 1;
    if (errors == 0 && contact_q.size() == 0) begin
      $display("circle_circle_contact_test: clean");
    end else begin
      $display("circle_circle_contact_test: errors");
    end
    $finish;
  end
endmodule

// ----- circle_circle_contact.f -----
design/ccc_pkg.sv
design/ccc_pair_if.sv
design/ccc_res_if.sv
design/ccc_sqrt.sv
design/ccc_div.sv
design/circle_circle_contact.sv
verif/circle_circle_contact_test.sv
